// ===== hdl/hcbp_pkg.sv =====
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

  localparam int unsigned WORD_BITS_DEF    = 64;
  localparam int unsigned SYMBOL_COUNT_DEF = 256;

  // Fixed widths of the stream fields.
  localparam int unsigned SYMBOL_BITS = 8;
  localparam int unsigned CODE_BITS   = 64;
  localparam int unsigned LENGTH_BITS = 7;
  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned S_DATA_BITS = 80;
  localparam int unsigned M_DATA_BITS = 64;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_e;

  // Control of the item held in the lookup stage.
  typedef struct packed {
    logic    valid;
    opcode_e op;
    logic    in_range;
  } stage_ctrl_t;

endpackage

// ===== hdl/hcbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hcbp_packer.sv =====
// Shift-merge of looked-up codes into the word accumulator, with the output register.
module hcbp_packer #(
  parameter int unsigned WORD_BITS = hcbp_pkg::WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hcbp_pkg::stage_ctrl_t             ctrl_i,
  input  logic [WORD_BITS-1:0]              code_i,
  input  logic [$clog2(WORD_BITS+1)-1:0]    len_i,
  output logic                              stage_ready_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hcbp_pkg::M_DATA_BITS-1:0]  m_axis_tdata,  // packed_word
  output logic                              m_axis_tlast   // is_final
);

  localparam int unsigned LEN_W   = $clog2(WORD_BITS + 1);
  localparam int unsigned FILL_W  = $clog2(WORD_BITS);
  localparam int unsigned SHIFT_W = $clog2(2 * WORD_BITS) + 1;

  logic [WORD_BITS-1:0]   acc_q, acc_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic                   out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0]   word_q, word_d;
  logic                   final_q, final_d;

  logic                   fire;
  logic                   emit;
  logic [SHIFT_W-1:0]     sum;
  logic [SHIFT_W-1:0]     shamt;
  logic [2*WORD_BITS-1:0] merged;

  assign stage_ready_o = !out_valid_q || m_axis_tready;
  assign fire          = ctrl_i.valid && stage_ready_o;

  // The code lands just below the bits already filled in a window two words wide;
  // the upper half is the word to emit once it is full, the lower half the overflow.
  assign sum    = SHIFT_W'(fill_q) + SHIFT_W'(len_i);
  assign shamt  = SHIFT_W'(2 * WORD_BITS) - sum;
  assign merged = {acc_q, {WORD_BITS{1'b0}}} | ((2 * WORD_BITS)'(code_i) << shamt);

  always_comb begin
    acc_d   = acc_q;
    fill_d  = fill_q;
    word_d  = word_q;
    final_d = final_q;
    emit    = 1'b0;
    if (fire) begin
      case (ctrl_i.op)
        hcbp_pkg::OP_ENCODE: begin
          if (ctrl_i.in_range && (len_i != LEN_W'(0))) begin
            if (sum >= SHIFT_W'(WORD_BITS)) begin
              emit    = 1'b1;
              word_d  = merged[2*WORD_BITS-1:WORD_BITS];
              final_d = 1'b0;
              acc_d   = merged[WORD_BITS-1:0];
              fill_d  = FILL_W'(sum - SHIFT_W'(WORD_BITS));
            end else begin
              acc_d  = merged[2*WORD_BITS-1:WORD_BITS];
              fill_d = FILL_W'(sum);
            end
          end
        end
        hcbp_pkg::OP_FLUSH: begin
          emit    = 1'b1;
          word_d  = acc_q;
          final_d = 1'b1;
          acc_d   = '0;
          fill_d  = '0;
        end
        default: begin
        end
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    final_q <= final_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = hcbp_pkg::M_DATA_BITS'(word_q);
  assign m_axis_tlast  = final_q;

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (ctrl_i.op == hcbp_pkg::OP_FLUSH) |=> (fill_q == '0) && (acc_q == '0)
      && out_valid_q && final_q)
    else $error("flush did not emit a final word and clear the accumulator");

  a_encode_not_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (ctrl_i.op == hcbp_pkg::OP_ENCODE) && emit |=> out_valid_q && !final_q)
    else $error("full word from an encode is marked final");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (ctrl_i.op == hcbp_pkg::OP_LOAD) |=> $stable(acc_q) && $stable(fill_q))
    else $error("table load disturbed the accumulator");

endmodule

// ===== hdl/huffman_code_bit_packer_top.sv =====
// Top level of the Huffman code bit packer: code table, lookup stage and packer.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser: opcode; tdata: symbol, entry_code, entry_length
//   m_axis    out        tdata: packed_word; tlast: is_final
//
// One item per cycle while m_axis is not stalled: a beat reads (or writes) the code
// table in its accept cycle; the lookup stage register and the RAM's registered
// read data then hold it until the packer merges the code into the accumulator and
// loads the output register. Reset clears the accumulator, fill count and valid
// flags; the table is not cleared and a symbol must be loaded before it is encoded.
// A stalled m_axis holds the lookup stage, which in turn drops s_axis_tready.
module huffman_code_bit_packer_top #(
  parameter int unsigned WORD_BITS    = hcbp_pkg::WORD_BITS_DEF,
  parameter int unsigned SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // symbol [7:0], entry_code [71:8], entry_length [78:72], zero [79]
  input  logic [hcbp_pkg::S_DATA_BITS-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [hcbp_pkg::OPCODE_BITS-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // packed_word [63:0]
  output logic [hcbp_pkg::M_DATA_BITS-1:0]  m_axis_tdata,
  // is_final
  output logic                              m_axis_tlast
);

  localparam int unsigned ADDR_W = $clog2(SYMBOL_COUNT);
  localparam int unsigned LEN_W  = $clog2(WORD_BITS + 1);
  localparam int unsigned SYM_LO = 0;
  localparam int unsigned CODE_LO = SYM_LO + hcbp_pkg::SYMBOL_BITS;
  localparam int unsigned LEN_LO  = CODE_LO + hcbp_pkg::CODE_BITS;

  logic [hcbp_pkg::SYMBOL_BITS-1:0] symbol;
  logic [hcbp_pkg::CODE_BITS-1:0]   entry_code;
  logic [hcbp_pkg::LENGTH_BITS-1:0] entry_length;
  hcbp_pkg::opcode_e                opcode;

  logic                   accept;
  logic                   in_range;
  logic                   stage_ready;
  logic [LEN_W-1:0]       len_clamped;
  logic [WORD_BITS:0]     len_mask;
  logic [WORD_BITS-1:0]   code_masked;
  logic [WORD_BITS+LEN_W-1:0] rd_entry;

  hcbp_pkg::stage_ctrl_t  s1_q, s1_d;

  assign symbol       = s_axis_tdata[SYM_LO +: hcbp_pkg::SYMBOL_BITS];
  assign entry_code   = s_axis_tdata[CODE_LO +: hcbp_pkg::CODE_BITS];
  assign entry_length = s_axis_tdata[LEN_LO +: hcbp_pkg::LENGTH_BITS];
  assign opcode       = hcbp_pkg::opcode_e'(s_axis_tuser);

  assign s_axis_tready = !s1_q.valid || stage_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = ({1'b0, symbol} < (hcbp_pkg::SYMBOL_BITS + 1)'(SYMBOL_COUNT));

  // Lengths above the word size are clamped, and code bits above the length dropped.
  assign len_clamped = (entry_length > hcbp_pkg::LENGTH_BITS'(WORD_BITS)) ?
                       LEN_W'(WORD_BITS) : LEN_W'(entry_length);
  assign len_mask    = ((WORD_BITS + 1)'(1) << len_clamped) - (WORD_BITS + 1)'(1);
  assign code_masked = entry_code[WORD_BITS-1:0] & len_mask[WORD_BITS-1:0];

  hcbp_ram #(
    .WIDTH (WORD_BITS + LEN_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept && (opcode == hcbp_pkg::OP_LOAD) && in_range),
    .waddr_i (symbol[ADDR_W-1:0]),
    .wdata_i ({len_clamped, code_masked}),
    .re_i    (accept && (opcode == hcbp_pkg::OP_ENCODE)),
    .raddr_i (symbol[ADDR_W-1:0]),
    .rdata_o (rd_entry)
  );

  always_comb begin
    s1_d = s1_q;
    if (s_axis_tready) begin
      s1_d.valid    = accept;
      s1_d.op       = opcode;
      s1_d.in_range = in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  hcbp_packer #(
    .WORD_BITS (WORD_BITS)
  ) u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (s1_q),
    .code_i        (rd_entry[WORD_BITS-1:0]),
    .len_i         (rd_entry[WORD_BITS+LEN_W-1:WORD_BITS]),
    .stage_ready_o (stage_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
